FILE: rtl/pcm_convert_saturating_mix_defines.svh
// Assertion macros for the PCM convert and mix block.
// Included by the checker; depends on nothing else.
`ifndef PCM_CONVERT_SATURATING_MIX_DEFINES_SVH
`define PCM_CONVERT_SATURATING_MIX_DEFINES_SVH

// Clocked property, masked while reset is high.
`define PCSM_ASSERT(name, clk, rst, prop) \
  name: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("pcsm check failed");

// Clocked property that must also hold through reset.
`define PCSM_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("pcsm check failed");

`endif

FILE: rtl/pcsm_pkg.sv
// Shared types, codes and the format table of the PCM convert and mix block.
// Standalone; used by the top level.
package pcsm_pkg;

  typedef enum logic [4:0] {
    FMT_U8        = 5'd0,
    FMT_S8        = 5'd1,
    FMT_U16LE     = 5'd2,
    FMT_S16LE     = 5'd3,
    FMT_U16BE     = 5'd4,
    FMT_S16BE     = 5'd5,
    FMT_U32LE     = 5'd6,
    FMT_S32LE     = 5'd7,
    FMT_U32BE     = 5'd8,
    FMT_S32BE     = 5'd9,
    FMT_U24IN32LE = 5'd10,
    FMT_S24IN32LE = 5'd11,
    FMT_U24IN32BE = 5'd12,
    FMT_S24IN32BE = 5'd13
  } fmt_code_t;

  typedef enum logic [1:0] {
    WID_8  = 2'd0,
    WID_16 = 2'd1,
    WID_32 = 2'd2
  } wid_t;

  typedef struct packed {
    logic ok;
    wid_t wid;
    logic sgn;
    logic be;
  } fmt_info_t;

  localparam logic [1:0] REG_SRC_FORMAT   = 2'd0;
  localparam logic [1:0] REG_DST_FORMAT   = 2'd1;
  localparam logic [1:0] REG_SRC_CHANNELS = 2'd2;

  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_BAD_FMT = 1'b1;

  localparam logic [4:0] SRC_FORMAT_RESET   = FMT_S16LE;
  localparam logic [4:0] DST_FORMAT_RESET   = FMT_S16LE;
  localparam logic [7:0] SRC_CHANNELS_RESET = 8'd2;

  function automatic fmt_info_t fmt_lookup(logic [4:0] code);
    fmt_info_t fi;
    fi = '{ok: 1'b1, wid: WID_32, sgn: 1'b0, be: 1'b0};
    unique case (code)
      FMT_U8:        fi.wid = WID_8;
      FMT_S8:        begin fi.wid = WID_8;  fi.sgn = 1'b1; end
      FMT_U16LE:     fi.wid = WID_16;
      FMT_S16LE:     begin fi.wid = WID_16; fi.sgn = 1'b1; end
      FMT_U16BE:     begin fi.wid = WID_16; fi.be = 1'b1; end
      FMT_S16BE:     begin fi.wid = WID_16; fi.sgn = 1'b1; fi.be = 1'b1; end
      FMT_U32LE:     fi.wid = WID_32;
      FMT_S32LE:     fi.sgn = 1'b1;
      FMT_U32BE:     fi.be = 1'b1;
      FMT_S32BE:     begin fi.sgn = 1'b1; fi.be = 1'b1; end
      FMT_U24IN32LE: fi.wid = WID_32;
      FMT_S24IN32LE: fi.sgn = 1'b1;
      FMT_U24IN32BE: fi.be = 1'b1;
      FMT_S24IN32BE: begin fi.sgn = 1'b1; fi.be = 1'b1; end
      default:       fi.ok = 1'b0;
    endcase
    return fi;
  endfunction

endpackage

FILE: rtl/pcm_convert_saturating_mix.sv
// PCM convert and mix: four-stage pipeline that decodes, adds, clamps and re-encodes.
// Depends on pcsm_pkg.
//
// Takes one destination sample and one source sample per request and returns their
// saturated sum in the destination format. One request is accepted every clock while
// the output side takes results; a request passes through the decode, add and clamp,
// rescale product and encode register stages in turn before its result appears.
// s_tready follows m_tready combinationally through the stage enables, so a stall
// holds every occupied stage and loses nothing. Values are carried in fixed point
// with 32 fractional bits. Configuration is taken every cycle and must only change
// while the pipeline is empty.
module pcm_convert_saturating_mix (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [71:0] s_tdata,   // dst_sample[31:0], src_sample[63:32], channel_index[71:64]
  input  logic        s_tuser,   // src_present
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // mixed_sample[31:0]
  output logic        m_tuser,   // status
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [7:0]  cfg_data
);
  import pcsm_pkg::*;

  localparam logic [33:0] ONE_Q = 34'h1_0000_0000;

  logic [4:0] src_format;
  logic [4:0] dst_format;
  logic [7:0] src_channels;
  fmt_info_t  src_fi;
  fmt_info_t  dst_fi;

  // stage registers
  logic               v1, v2, v3;
  logic signed [33:0] a1, b1;
  logic [31:0]        raw1, raw2, raw3;
  logic [33:0]        t2;
  logic [31:0]        q3;
  logic               fnz3;

  logic               en1, en2, en3, en4;
  logic signed [33:0] a_dec, b_dec;
  logic               src_live;
  logic signed [34:0] sum, clamped, t_wide;
  logic [65:0]        prod;
  logic [32:0]        half, f;
  logic [31:0]        x_enc, mask, enc_out;

  // Decode a raw code to a value in [-1, 1]. With A = 2u and M = 2^n - 1,
  // floor(A * 2^32 / M) = A * (2^32 - 1) / M + floor(A / M), and the first
  // factor is a byte replication pattern.
  function automatic logic signed [33:0] decode(logic [31:0] raw, fmt_info_t fi);
    logic [31:0] x;
    logic [32:0] a;
    logic [32:0] m;
    logic [33:0] q;
    logic        ge1, ge2;
    x = 32'd0;
    m = 33'd1;
    unique case (fi.wid)
      WID_8: begin
        x = {24'd0, raw[7:0]};
        if (fi.sgn) x[7] = ~x[7];
        m = {25'd0, 8'hFF};
      end
      WID_16: begin
        x = fi.be ? {16'd0, raw[7:0], raw[15:8]} : {16'd0, raw[15:0]};
        if (fi.sgn) x[15] = ~x[15];
        m = {17'd0, 16'hFFFF};
      end
      WID_32: begin
        x = fi.be ? {raw[7:0], raw[15:8], raw[23:16], raw[31:24]} : raw;
        if (fi.sgn) x[31] = ~x[31];
        m = {1'b0, 32'hFFFF_FFFF};
      end
      default: begin
        x = 32'd0;
        m = 33'd1;
      end
    endcase
    a = {x, 1'b0};
    unique case (fi.wid)
      WID_8:   q = {1'b0, a} + {a[25:0], 8'd0} + {a[17:0], 16'd0} + {a[9:0], 24'd0};
      WID_16:  q = {1'b0, a} + {a[17:0], 16'd0};
      default: q = {1'b0, a};
    endcase
    ge1 = (a >= m);
    ge2 = ({1'b0, a} >= {m, 1'b0});
    q = q + {33'd0, ge1} + {33'd0, ge2};
    return $signed(q - ONE_Q);
  endfunction

  assign src_fi    = fmt_lookup(src_format);
  assign dst_fi    = fmt_lookup(dst_format);
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      src_format   <= SRC_FORMAT_RESET;
      dst_format   <= DST_FORMAT_RESET;
      src_channels <= SRC_CHANNELS_RESET;
    end else if (cfg_valid && cfg_ready && cfg_index[7:2] == 6'd0) begin
      unique case (cfg_index[1:0])
        REG_SRC_FORMAT:   src_format   <= cfg_data[4:0];
        REG_DST_FORMAT:   dst_format   <= cfg_data[4:0];
        REG_SRC_CHANNELS: src_channels <= cfg_data;
        default: ;
      endcase
    end
  end

  // advance a stage when it is empty or the one after it advances
  assign en4      = !m_tvalid || m_tready;
  assign en3      = !v3 || en4;
  assign en2      = !v2 || en3;
  assign en1      = !v1 || en2;
  assign s_tready = en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1       <= 1'b0;
      v2       <= 1'b0;
      v3       <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (en1) v1 <= s_tvalid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) m_tvalid <= v3;
    end
  end

  // stage 1: decode both samples; silence an absent or unusable source
  assign src_live = s_tuser && (s_tdata[71:64] < src_channels) && src_fi.ok;
  assign a_dec    = decode(s_tdata[31:0], dst_fi);
  assign b_dec    = src_live ? decode(s_tdata[63:32], src_fi) : 34'sd0;

  always_ff @(posedge clk) begin
    if (en1) begin
      a1   <= a_dec;
      b1   <= b_dec;
      raw1 <= s_tdata[31:0];
    end
  end

  // stage 2: add, clamp to [-1, 1], offset to [0, 2]
  always_comb begin
    sum = 35'(a1) + 35'(b1);
    priority if (sum < -$signed({1'b0, ONE_Q})) clamped = -$signed({1'b0, ONE_Q});
    else if (sum > $signed({1'b0, ONE_Q}))      clamped = $signed({1'b0, ONE_Q});
    else                                        clamped = sum;
    t_wide = clamped + $signed({1'b0, ONE_Q});
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      t2   <= t_wide[33:0];
      raw2 <= raw1;
    end
  end

  // stage 3: t * M as (t << n) - t, keep the integer part of half the product and a sticky fraction
  always_comb begin
    unique case (dst_fi.wid)
      WID_8:   prod = ({32'd0, t2} << 8) - {32'd0, t2};
      WID_16:  prod = ({32'd0, t2} << 16) - {32'd0, t2};
      default: prod = ({32'd0, t2} << 32) - {32'd0, t2};
    endcase
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      q3   <= prod[64:33];
      fnz3 <= |prod[32:0];
      raw3 <= raw2;
    end
  end

  // stage 4: remove the signed offset, round toward zero, mask and swap
  always_comb begin
    unique case (dst_fi.wid)
      WID_8: begin
        half = dst_fi.sgn ? 33'h80 : 33'd0;
        mask = 32'hFF;
      end
      WID_16: begin
        half = dst_fi.sgn ? 33'h8000 : 33'd0;
        mask = 32'hFFFF;
      end
      default: begin
        half = dst_fi.sgn ? 33'h8000_0000 : 33'd0;
        mask = 32'hFFFF_FFFF;
      end
    endcase
    f = {1'b0, q3} - half;
    if (f[32] && fnz3) f = f + 33'd1;
    x_enc = f[31:0] & mask;
    enc_out = x_enc;
    if (dst_fi.be) begin
      unique case (dst_fi.wid)
        WID_16:  enc_out = {16'd0, x_enc[7:0], x_enc[15:8]};
        WID_32:  enc_out = {x_enc[7:0], x_enc[15:8], x_enc[23:16], x_enc[31:24]};
        default: enc_out = x_enc;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      m_tdata <= dst_fi.ok ? enc_out : raw3;
      m_tuser <= dst_fi.ok ? STATUS_OK : STATUS_BAD_FMT;
    end
  end

endmodule

FILE: rtl/pcsm_checker.sv
// Port-level checks for the PCM convert and mix block, bound to the top level.
// Depends on pcm_convert_saturating_mix_defines.svh.
`include "pcm_convert_saturating_mix_defines.svh"

module pcsm_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic        m_tuser
);

  // drop any result in flight on reset
  `PCSM_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !m_tvalid)

  // an open output lets every stage advance, so the input must be open too
  `PCSM_ASSERT(a_ready_follows, clk, rst, m_tready |-> s_tready)

  // a request meets an open output path and appears after four stages
  `PCSM_ASSERT(a_latency, clk, rst, (s_tvalid && s_tready) ##1 m_tready ##1 m_tready ##1 m_tready |=> m_tvalid)

  // hold a result under stall
  `PCSM_ASSERT(a_hold, clk, rst, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))

endmodule

bind pcm_convert_saturating_mix pcsm_checker u_pcsm_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
